>>> hw/rtl/pls_pkg.sv
// Package for the polyline segment to triangles unit.
// Holds register indexes, back-end sequencer states and fixed constants.
// Depends on nothing; every other file of the unit imports it.
`default_nettype none

package pls_pkg;

    // Configuration bus: 64-bit data, registers on 8-byte boundaries.
    localparam int ADDR_WIDTH  = 6;
    localparam int DATA_WIDTH  = 64;

    // Normalized magnitudes stay below 2^31.
    localparam int NORM_BITS   = 31;
    // The divider always produces a 32-bit quotient.
    localparam int QUOT_BITS   = 32;
    // Lag of the older fade ramp behind the newer one.
    localparam int FADE_LAG    = 25;
    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        REG_START_X          = 3'd0,
        REG_START_Y          = 3'd1,
        REG_START_COUNT      = 3'd2,
        REG_TOTAL_LENGTH     = 3'd3,
        REG_WIDTH_HORIZONTAL = 3'd4,
        REG_WIDTH_VERTICAL   = 3'd5,
        REG_RGBA_COLOR       = 3'd6,
        REG_FADE_ENABLE      = 3'd7
    } reg_index_t;

    typedef enum logic [4:0] {
        B_IDLE,
        B_NORM,
        B_SQA,
        B_SQB,
        B_SUM,
        B_SQRT,
        B_MULX,
        B_DXS,
        B_DXW,
        B_MULY,
        B_DYS,
        B_DYW,
        B_FADE,
        B_FCS,
        B_FCW,
        B_FPS,
        B_FPW,
        B_ALC,
        B_ALP,
        B_EMIT
    } back_state_t;

    localparam logic [2:0] LAST_VERTEX = 3'd5;

endpackage

`default_nettype wire

>>> hw/rtl/pls_fifo.sv
// Short register queue that decouples the front and the back of the unit.
// Depends on pls_pkg for its depth.
`default_nettype none

module pls_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr,
    input  wire logic [WIDTH-1:0] din,
    output logic                  full,
    input  wire logic             rd,
    output logic [WIDTH-1:0]      dout,
    output logic                  empty
);
    import pls_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wptr_reg;
    logic [PW-1:0]    rptr_reg;
    logic [CW-1:0]    count_reg;

    assign full  = (count_reg == CW'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wptr_reg <= (wptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (rd)
            begin
                rptr_reg <= (rptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (wr && !rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd && !wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/pls_front.sv
// Front end: accepts end points, keeps the previous point and the item count,
// and classifies each segment (deltas, zero length, fade position).
// Depends on pls_pkg.
`default_nettype none

module pls_front #(
    parameter int CW = 32,
    parameter int EW = 1 + 32 + 2 * (CW + 1) + 4 * CW
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire logic signed [CW-1:0] point_x,
    input  wire logic signed [CW-1:0] point_y,
    input  wire logic                 q_full,
    input  wire logic signed [CW-1:0] start_x,
    input  wire logic signed [CW-1:0] start_y,
    input  wire logic [31:0]          start_count,
    output logic                      q_wr,
    output logic [EW-1:0]             q_din
);
    import pls_pkg::*;

    logic signed [CW-1:0] prior_x_reg;
    logic signed [CW-1:0] prior_y_reg;
    logic                 first_item_reg;
    logic [31:0]          items_seen_reg;

    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW:0]   dx;
    logic signed [CW:0]   dy;
    logic [31:0]          n;
    logic                 zero_len;

    always_comb
    begin
        px       = first_item_reg ? start_x : prior_x_reg;
        py       = first_item_reg ? start_y : prior_y_reg;
        dx       = {point_x[CW-1], point_x} - {px[CW-1], px};
        dy       = {point_y[CW-1], point_y} - {py[CW-1], py};
        n        = start_count + items_seen_reg;
        zero_len = (point_x == px) && (point_y == py);
    end

    assign q_wr  = push && !q_full;
    assign q_din = {zero_len, n, dx, dy, point_x, point_y, px, py};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_x_reg    <= '0;
            prior_y_reg    <= '0;
            first_item_reg <= 1'b1;
            items_seen_reg <= '0;
        end
        else if (q_wr)
        begin
            prior_x_reg    <= point_x;
            prior_y_reg    <= point_y;
            first_item_reg <= 1'b0;
            items_seen_reg <= items_seen_reg + 32'd1;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/pls_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit quotient.
// The caller guarantees that the quotient fits in 32 bits. Depends on pls_pkg.
`default_nettype none

module pls_div (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [63:0]            num,
    input  wire logic [32:0]            den,
    output logic                        done,
    output logic [pls_pkg::QUOT_BITS-1:0] quot
);
    import pls_pkg::*;

    localparam int CNTW = $clog2(QUOT_BITS);

    logic [32:0]          rem_reg;
    logic [31:0]          low_reg;
    logic [32:0]          den_reg;
    logic [QUOT_BITS-1:0] quot_reg;
    logic [CNTW-1:0]      cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [33:0] trial;
    logic        take;
    logic [33:0] diff;

    always_comb
    begin
        trial = {rem_reg, low_reg[31]};
        take  = (trial >= {1'b0, den_reg});
        diff  = trial - {1'b0, den_reg};
    end

    assign done = done_reg;
    assign quot = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(QUOT_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num[63:32]};
            low_reg <= num[31:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg  <= take ? diff[32:0] : trial[32:0];
            low_reg  <= {low_reg[30:0], 1'b0};
            quot_reg <= {quot_reg[QUOT_BITS-2:0], take};
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/pls_back.sv
// Back end: normalizes the segment, takes the square root bit-serially, forms
// the offsets and fade factors on a shared divider and emits six vertices.
// Depends on pls_pkg and pls_div.
`default_nettype none

module pls_back #(
    parameter int CW   = 32,
    parameter int COLW = 16,
    parameter int EW   = 1 + 32 + 2 * (CW + 1) + 4 * CW
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_empty,
    input  wire logic [EW-1:0]        q_dout,
    output logic                      q_rd,
    input  wire logic [30:0]          width_horizontal,
    input  wire logic [30:0]          width_vertical,
    input  wire logic [31:0]          total_length,
    input  wire logic [63:0]          rgba_color,
    input  wire logic                 fade_enable,
    input  wire logic                 pop,
    output logic                      empty,
    output logic signed [CW-1:0]      vertex_x,
    output logic signed [CW-1:0]      vertex_y,
    output logic [2:0]                vertex_index,
    output logic                      vertex_valid,
    output logic [COLW-1:0]           red,
    output logic [COLW-1:0]           green,
    output logic [COLW-1:0]           blue,
    output logic [COLW-1:0]           alpha,
    output logic                      last_vertex
);
    import pls_pkg::*;

    localparam int MW  = (CW + 1 > 32) ? CW + 1 : 32;
    localparam int SW  = ((CW > 32) ? CW : 32) + 2;
    localparam int XW  = (4 * COLW > 64) ? 4 * COLW : 64;
    localparam int PW  = 2 * COLW + 1;
    localparam logic [COLW-1:0] COL_ONE = {1'b1, {(COLW - 1){1'b0}}};
    localparam longint SAT_HI_L = (longint'(1) <<< (CW - 1)) - 1;
    localparam logic signed [SW-1:0] SAT_HI = SW'(SAT_HI_L);
    localparam logic signed [SW-1:0] SAT_LO = SW'(-SAT_HI_L - 1);

    function automatic logic [COLW-1:0] scale_alpha(input logic [COLW-1:0] a,
                                                    input logic [COLW-1:0] f);
        logic [PW-1:0] p;
        p = PW'(a) * PW'(f) + PW'(COL_ONE >> 1);
        return p[COLW-1 +: COLW];
    endfunction

    function automatic logic [COLW-1:0] clamp_one(input logic [COLW-1:0] v);
        return (v > COL_ONE) ? COL_ONE : v;
    endfunction

    function automatic logic [CW-1:0] sat_coord(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] c;
        c = v;
        if (v > SAT_HI)
        begin
            c = SAT_HI;
        end
        else if (v < SAT_LO)
        begin
            c = SAT_LO;
        end
        return c[CW-1:0];
    endfunction

    // Queue entry fields.
    logic                 e_zero;
    logic [31:0]          e_n;
    logic signed [CW:0]   e_dx;
    logic signed [CW:0]   e_dy;
    logic signed [CW-1:0] e_cx;
    logic signed [CW-1:0] e_cy;
    logic signed [CW-1:0] e_px;
    logic signed [CW-1:0] e_py;
    logic [CW:0]          e_ax;
    logic [CW:0]          e_ay;

    assign {e_zero, e_n, e_dx, e_dy, e_cx, e_cy, e_px, e_py} = q_dout;

    back_state_t state_reg;
    back_state_t state_next;

    logic signed [CW-1:0] cx_reg;
    logic signed [CW-1:0] cy_reg;
    logic signed [CW-1:0] px_reg;
    logic signed [CW-1:0] py_reg;
    logic [MW-1:0]        a_reg;
    logic [MW-1:0]        b_reg;
    logic                 dx_pos_reg;
    logic                 dx_neg_reg;
    logic                 dy_pos_reg;
    logic                 dy_neg_reg;
    logic [31:0]          n_reg;
    logic                 valid_reg;
    logic [62:0]          acc_reg;
    logic [61:0]          prod_reg;
    logic [62:0]          rem_reg;
    logic [62:0]          root_reg;
    logic [62:0]          bit_reg;
    logic [31:0]          len_reg;
    logic signed [31:0]   ox_reg;
    logic signed [31:0]   oy_reg;
    logic [31:0]          d_reg;
    logic                 need_cur_reg;
    logic                 need_prior_reg;
    logic [COLW-1:0]      fcur_reg;
    logic [COLW-1:0]      fprior_reg;
    logic [COLW-1:0]      alpha_c_reg;
    logic [COLW-1:0]      alpha_p_reg;
    logic [2:0]           k_reg;

    logic                 out_valid_reg;
    logic signed [CW-1:0] vx_reg;
    logic signed [CW-1:0] vy_reg;
    logic [2:0]           vidx_reg;
    logic                 vvalid_reg;
    logic [COLW-1:0]      red_reg;
    logic [COLW-1:0]      green_reg;
    logic [COLW-1:0]      blue_reg;
    logic [COLW-1:0]      alpha_reg;
    logic                 last_reg;

    logic [NORM_BITS-1:0] a31;
    logic [NORM_BITS-1:0] b31;
    logic                 need_shift;
    logic [63:0]          sq_trial;
    logic                 sq_take;
    logic [62:0]          root_step;
    logic [62:0]          rem_step;
    logic                 fade_on;
    logic [31:0]          d_cfg;
    logic [31:0]          m_prior;
    logic [XW-1:0]        rgba_ext;
    logic [COLW-1:0]      ch_red;
    logic [COLW-1:0]      ch_green;
    logic [COLW-1:0]      ch_blue;
    logic [COLW-1:0]      ch_alpha;
    logic                 slot_free;
    logic                 at_end;
    logic                 plus;
    logic signed [SW-1:0] base_x;
    logic signed [SW-1:0] base_y;
    logic signed [SW-1:0] sum_x;
    logic signed [SW-1:0] sum_y;

    logic                 div_start;
    logic [63:0]          div_num;
    logic [32:0]          div_den;
    logic                 div_done;
    logic [QUOT_BITS-1:0] div_quot;

    pls_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        e_ax       = e_dx[CW] ? (CW + 1)'(-e_dx) : e_dx;
        e_ay       = e_dy[CW] ? (CW + 1)'(-e_dy) : e_dy;
        a31        = a_reg[NORM_BITS-1:0];
        b31        = b_reg[NORM_BITS-1:0];
        need_shift = ((a_reg | b_reg) >> NORM_BITS) != '0;

        sq_trial   = 64'(root_reg) + 64'(bit_reg);
        sq_take    = 64'(rem_reg) >= sq_trial;
        root_step  = sq_take ? (root_reg >> 1) + bit_reg : (root_reg >> 1);
        rem_step   = sq_take ? rem_reg - sq_trial[62:0] : rem_reg;

        fade_on    = fade_enable && (total_length > 32'(FADE_LAG));
        d_cfg      = total_length - 32'(FADE_LAG);
        m_prior    = n_reg - 32'(FADE_LAG);

        rgba_ext   = XW'(rgba_color);
        ch_alpha   = clamp_one(rgba_ext[0 +: COLW]);
        ch_blue    = clamp_one(rgba_ext[COLW +: COLW]);
        ch_green   = clamp_one(rgba_ext[2 * COLW +: COLW]);
        ch_red     = clamp_one(rgba_ext[3 * COLW +: COLW]);

        // Vertices 1, 4 and 5 sit at the new point; 2, 3 and 5 add the offset.
        at_end     = (k_reg == 3'd1) || (k_reg == 3'd4) || (k_reg == 3'd5);
        plus       = (k_reg == 3'd2) || (k_reg == 3'd3) || (k_reg == 3'd5);
        base_x     = SW'(at_end ? cx_reg : px_reg);
        base_y     = SW'(at_end ? cy_reg : py_reg);
        sum_x      = plus ? base_x + SW'(ox_reg) : base_x - SW'(ox_reg);
        sum_y      = plus ? base_y + SW'(oy_reg) : base_y - SW'(oy_reg);

        slot_free  = !out_valid_reg || pop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_rd       = 1'b0;
        div_start  = 1'b0;
        div_num    = 64'(acc_reg) + 64'(len_reg);
        div_den    = {len_reg, 1'b0};
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_rd       = 1'b1;
                    state_next = B_NORM;
                end
            end
            B_NORM:
            begin
                if (!need_shift)
                begin
                    state_next = B_SQA;
                end
            end
            B_SQA:  state_next = B_SQB;
            B_SQB:  state_next = B_SUM;
            B_SUM:  state_next = valid_reg ? B_SQRT : B_EMIT;
            B_SQRT:
            begin
                if (bit_reg[0])
                begin
                    state_next = B_MULX;
                end
            end
            B_MULX: state_next = B_DXS;
            B_DXS:
            begin
                div_start  = 1'b1;
                state_next = B_DXW;
            end
            B_DXW:
            begin
                if (div_done)
                begin
                    state_next = B_MULY;
                end
            end
            B_MULY: state_next = B_DYS;
            B_DYS:
            begin
                div_start  = 1'b1;
                state_next = B_DYW;
            end
            B_DYW:
            begin
                if (div_done)
                begin
                    state_next = B_FADE;
                end
            end
            B_FADE: state_next = B_FCS;
            B_FCS:
            begin
                div_num    = (64'(n_reg) << (COLW - 1)) + 64'(d_reg >> 1);
                div_den    = 33'(d_reg);
                div_start  = need_cur_reg;
                state_next = need_cur_reg ? B_FCW : B_FPS;
            end
            B_FCW:
            begin
                if (div_done)
                begin
                    state_next = B_FPS;
                end
            end
            B_FPS:
            begin
                div_num    = (64'(m_prior) << (COLW - 1)) + 64'(d_reg >> 1);
                div_den    = 33'(d_reg);
                div_start  = need_prior_reg;
                state_next = need_prior_reg ? B_FPW : B_ALC;
            end
            B_FPW:
            begin
                if (div_done)
                begin
                    state_next = B_ALC;
                end
            end
            B_ALC:  state_next = B_ALP;
            B_ALP:  state_next = B_EMIT;
            B_EMIT:
            begin
                if (slot_free && (k_reg == LAST_VERTEX))
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (q_rd)
                begin
                    cx_reg     <= e_cx;
                    cy_reg     <= e_cy;
                    px_reg     <= e_px;
                    py_reg     <= e_py;
                    a_reg      <= MW'(e_ax);
                    b_reg      <= MW'(e_ay);
                    dx_pos_reg <= !e_dx[CW] && (e_dx != '0);
                    dx_neg_reg <= e_dx[CW];
                    dy_pos_reg <= !e_dy[CW] && (e_dy != '0);
                    dy_neg_reg <= e_dy[CW];
                    n_reg      <= e_n;
                    valid_reg  <= !e_zero;
                    k_reg      <= '0;
                end
            end
            B_NORM:
            begin
                if (need_shift)
                begin
                    a_reg <= a_reg >> 1;
                    b_reg <= b_reg >> 1;
                end
            end
            B_SQA:  acc_reg  <= 63'(62'(a31) * 62'(a31));
            B_SQB:  prod_reg <= 62'(b31) * 62'(b31);
            B_SUM:
            begin
                rem_reg  <= acc_reg + 63'(prod_reg);
                root_reg <= '0;
                bit_reg  <= {1'b1, 62'd0};
            end
            B_SQRT:
            begin
                rem_reg  <= rem_step;
                root_reg <= root_step;
                bit_reg  <= bit_reg >> 2;
                if (bit_reg[0])
                begin
                    len_reg <= root_step[31:0];
                end
            end
            B_MULX: acc_reg <= 63'(62'(width_horizontal) * 62'(b31));
            B_DXW:
            begin
                if (div_done)
                begin
                    ox_reg <= dy_pos_reg ? -signed'(div_quot) :
                              (dy_neg_reg ? signed'(div_quot) : 32'sd0);
                end
            end
            B_MULY: acc_reg <= 63'(62'(width_vertical) * 62'(a31));
            B_DYW:
            begin
                if (div_done)
                begin
                    oy_reg <= dx_pos_reg ? signed'(div_quot) :
                              (dx_neg_reg ? -signed'(div_quot) : 32'sd0);
                end
            end
            B_FADE:
            begin
                d_reg          <= d_cfg;
                fcur_reg       <= COL_ONE;
                need_cur_reg   <= fade_on && (n_reg < d_cfg);
                need_prior_reg <= fade_on && (n_reg > 32'(FADE_LAG)) && (m_prior < d_cfg);
                if (fade_on && (n_reg <= 32'(FADE_LAG)))
                begin
                    fprior_reg <= '0;
                end
                else
                begin
                    fprior_reg <= COL_ONE;
                end
            end
            B_FCW:
            begin
                if (div_done)
                begin
                    fcur_reg <= div_quot[COLW-1:0];
                end
            end
            B_FPW:
            begin
                if (div_done)
                begin
                    fprior_reg <= div_quot[COLW-1:0];
                end
            end
            B_ALC:  alpha_c_reg <= scale_alpha(ch_alpha, fcur_reg);
            B_ALP:  alpha_p_reg <= scale_alpha(ch_alpha, fprior_reg);
            B_EMIT:
            begin
                if (slot_free)
                begin
                    k_reg <= (k_reg == LAST_VERTEX) ? 3'd0 : k_reg + 3'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output register: holds one vertex until it is popped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == B_EMIT) && slot_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == B_EMIT) && slot_free)
        begin
            vidx_reg <= k_reg;
            last_reg <= (k_reg == LAST_VERTEX);
            if (valid_reg)
            begin
                vx_reg     <= sat_coord(sum_x);
                vy_reg     <= sat_coord(sum_y);
                vvalid_reg <= 1'b1;
                red_reg    <= ch_red;
                green_reg  <= ch_green;
                blue_reg   <= ch_blue;
                alpha_reg  <= at_end ? alpha_c_reg : alpha_p_reg;
            end
            else
            begin
                vx_reg     <= '0;
                vy_reg     <= '0;
                vvalid_reg <= 1'b0;
                red_reg    <= '0;
                green_reg  <= '0;
                blue_reg   <= '0;
                alpha_reg  <= '0;
            end
        end
    end

    assign empty        = !out_valid_reg;
    assign vertex_x     = vx_reg;
    assign vertex_y     = vy_reg;
    assign vertex_index = vidx_reg;
    assign vertex_valid = vvalid_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign alpha        = alpha_reg;
    assign last_vertex  = last_reg;

endmodule

`default_nettype wire

>>> hw/rtl/polyline_segment_to_triangles_unit.sv
// Polyline segment to triangles: one end point in, six triangle vertices out.
// The back takes one segment at a time: up to COORD_WIDTH-30 normalization
// shifts, a one-bit-per-cycle square root and up to four runs of the shared
// 32-step divider; a zero-length segment skips the root and the divider.
// The queue keeps taking points while the back is busy.
// Asynchronous active-low reset clears the control and configuration state.
`default_nettype none

module polyline_segment_to_triangles_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int COLOR_WIDTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Configuration port.
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [pls_pkg::ADDR_WIDTH-1:0]   paddr,
    input  wire logic [pls_pkg::DATA_WIDTH-1:0]   pwdata,
    output logic [pls_pkg::DATA_WIDTH-1:0]        prdata,
    output logic                                  pready,
    // Request side.
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic signed [COORD_WIDTH-1:0]    point_x,
    input  wire logic signed [COORD_WIDTH-1:0]    point_y,
    // Result side.
    output logic                                  empty,
    input  wire logic                             pop,
    output logic signed [COORD_WIDTH-1:0]         vertex_x,
    output logic signed [COORD_WIDTH-1:0]         vertex_y,
    output logic [2:0]                            vertex_index,
    output logic                                  vertex_valid,
    output logic [COLOR_WIDTH-1:0]                red,
    output logic [COLOR_WIDTH-1:0]                green,
    output logic [COLOR_WIDTH-1:0]                blue,
    output logic [COLOR_WIDTH-1:0]                alpha,
    output logic                                  last_vertex
);
    import pls_pkg::*;

    // One queue entry: zero flag, fade position, deltas and both end points.
    localparam int EW = 1 + 32 + 2 * (COORD_WIDTH + 1) + 4 * COORD_WIDTH;

    // Configuration registers. The line widths reset to 1.0 in unsigned Q15.16.
    logic signed [COORD_WIDTH-1:0] start_x_reg;
    logic signed [COORD_WIDTH-1:0] start_y_reg;
    logic [31:0]                   start_count_reg;
    logic [31:0]                   total_length_reg;
    logic [30:0]                   width_h_reg;
    logic [30:0]                   width_v_reg;
    logic [63:0]                   rgba_reg;
    logic                          fade_reg;

    logic       cfg_write;
    reg_index_t cfg_index;

    // Registers are 8 bytes apart; the low three address bits are ignored.
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[ADDR_WIDTH-1:3]);
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg      <= '0;
            start_y_reg      <= '0;
            start_count_reg  <= '0;
            total_length_reg <= '0;
            width_h_reg      <= 31'd65536;
            width_v_reg      <= 31'd65536;
            rgba_reg         <= '0;
            fade_reg         <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_START_X:          start_x_reg      <= pwdata[COORD_WIDTH-1:0];
                REG_START_Y:          start_y_reg      <= pwdata[COORD_WIDTH-1:0];
                REG_START_COUNT:      start_count_reg  <= pwdata[31:0];
                REG_TOTAL_LENGTH:     total_length_reg <= pwdata[31:0];
                REG_WIDTH_HORIZONTAL: width_h_reg      <= pwdata[30:0];
                REG_WIDTH_VERTICAL:   width_v_reg      <= pwdata[30:0];
                REG_RGBA_COLOR:       rgba_reg         <= pwdata[63:0];
                REG_FADE_ENABLE:      fade_reg         <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // Read back; the start point is returned sign-extended.
    always_comb
    begin
        case (cfg_index)
            REG_START_X:
                prdata = {{(DATA_WIDTH - COORD_WIDTH){start_x_reg[COORD_WIDTH-1]}},
                          start_x_reg};
            REG_START_Y:
                prdata = {{(DATA_WIDTH - COORD_WIDTH){start_y_reg[COORD_WIDTH-1]}},
                          start_y_reg};
            REG_START_COUNT:      prdata = DATA_WIDTH'(start_count_reg);
            REG_TOTAL_LENGTH:     prdata = DATA_WIDTH'(total_length_reg);
            REG_WIDTH_HORIZONTAL: prdata = DATA_WIDTH'(width_h_reg);
            REG_WIDTH_VERTICAL:   prdata = DATA_WIDTH'(width_v_reg);
            REG_RGBA_COLOR:       prdata = DATA_WIDTH'(rgba_reg);
            REG_FADE_ENABLE:      prdata = DATA_WIDTH'(fade_reg);
            default:              prdata = '0;
        endcase
    end

    // The front takes a request whenever the queue has room, so new points
    // keep arriving while the back is still busy with an earlier segment.
    logic          q_wr;
    logic          q_rd;
    logic          q_full;
    logic          q_empty;
    logic [EW-1:0] q_din;
    logic [EW-1:0] q_dout;

    assign full = q_full;

    pls_front #(
        .CW (COORD_WIDTH),
        .EW (EW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .point_x     (point_x),
        .point_y     (point_y),
        .q_full      (q_full),
        .start_x     (start_x_reg),
        .start_y     (start_y_reg),
        .start_count (start_count_reg),
        .q_wr        (q_wr),
        .q_din       (q_din)
    );

    pls_fifo #(
        .WIDTH (EW)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .din   (q_din),
        .full  (q_full),
        .rd    (q_rd),
        .dout  (q_dout),
        .empty (q_empty)
    );

    // The back turns each segment into six vertices, held one at a time in
    // an output register until popped.
    pls_back #(
        .CW   (COORD_WIDTH),
        .COLW (COLOR_WIDTH),
        .EW   (EW)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_dout           (q_dout),
        .q_rd             (q_rd),
        .width_horizontal (width_h_reg),
        .width_vertical   (width_v_reg),
        .total_length     (total_length_reg),
        .rgba_color       (rgba_reg),
        .fade_enable      (fade_reg),
        .pop              (pop),
        .empty            (empty),
        .vertex_x         (vertex_x),
        .vertex_y         (vertex_y),
        .vertex_index     (vertex_index),
        .vertex_valid     (vertex_valid),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .alpha            (alpha),
        .last_vertex      (last_vertex)
    );

endmodule

`default_nettype wire
